// ===== hw/rtl/atb_pkg.sv =====
// Package for the axisymmetric triangle strain-displacement block.
// Holds field widths, status codes, the element record type and helpers.
// Depends on nothing.
package atb_pkg;

    localparam int DATA_W = 32;
    localparam int DIFF_W = 33;
    localparam int SUM_W  = 34;
    localparam int PROD_W = 66;
    localparam int AM_W   = 67;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_CW   = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    typedef struct packed {
        logic [AM_W-1:0]             am;
        logic                        aneg;
        logic                        zero;
        logic [SUM_W-1:0]            sr;
        logic [SUM_W-1:0]            sz;
        logic [2:0][DIFF_W-1:0]      beta;
        logic [2:0][DIFF_W-1:0]      gamma;
    } t_elem;

    function automatic logic [DIFF_W-1:0] mag_diff(input logic [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
    endfunction

    function automatic logic [SUM_W-1:0] mag_sum(input logic [SUM_W-1:0] v);
        return v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
    endfunction

endpackage

// ===== hw/rtl/atb_if.sv =====
// Handshake interfaces for the element input and the node result channels.
// Depends on nothing.
interface atb_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r_first;
    logic signed [31:0] z_first;
    logic signed [31:0] r_second;
    logic signed [31:0] z_second;
    logic signed [31:0] r_third;
    logic signed [31:0] z_third;
    modport source (output valid, r_first, z_first, r_second, z_second, r_third, z_third,
                    input ready);
    modport sink (input valid, r_first, z_first, r_second, z_second, r_third, z_third,
                  output ready);
endinterface

interface atb_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         node_index;
    logic [1:0]         status;
    logic signed [31:0] radial_term;
    logic signed [31:0] axial_term;
    logic signed [31:0] hoop_term;
    logic signed [31:0] tri_area;
    logic signed [31:0] r_centroid;
    logic signed [31:0] z_centroid;
    logic               last;
    modport source (output valid, node_index, status, radial_term, axial_term, hoop_term,
                    tri_area, r_centroid, z_centroid, last, input ready);
    modport sink (input valid, node_index, status, radial_term, axial_term, hoop_term,
                  tri_area, r_centroid, z_centroid, last, output ready);
endinterface

// ===== hw/rtl/atb_fifo.sv =====
// Short queue of element records between the front and back parts.
// Depends on atb_pkg.
module atb_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  atb_pkg::t_elem i_data,
    output logic           o_full,
    input  logic           i_pop,
    output atb_pkg::t_elem o_data,
    output logic           o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    atb_pkg::t_elem  r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end
endmodule

// ===== hw/rtl/atb_front.sv =====
// Front part: accepts elements, forms node coefficients, sums and twice the area.
// Depends on atb_pkg and atb_in_if.
module atb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    atb_in_if.sink         i_in,
    output logic           o_push,
    output atb_pkg::t_elem o_elem,
    input  logic           i_full
);
    localparam int DW = atb_pkg::DIFF_W;
    localparam int SW = atb_pkg::SUM_W;
    localparam int PW = atb_pkg::PROD_W;
    localparam int AW = atb_pkg::AM_W;

    logic                  w_en;
    logic                  r_v1;
    logic                  r_v2;
    logic [DW-1:0]         r_a1, r_a2, r_c1, r_c2;
    logic [SW-1:0]         r1_sr, r1_sz, r2_sr, r2_sz;
    logic [2:0][DW-1:0]    r1_beta, r1_gamma, r2_beta, r2_gamma;
    logic [PW-1:0]         r_pm, r_qm;
    logic                  r_pneg, r_qneg;
    logic signed [DW-1:0]  w_r0, w_r1, w_r2, w_z0, w_z1, w_z2;
    logic [AW-1:0]         w_am;
    logic                  w_aneg;

    assign w_en       = !r_v2 || !i_full;
    assign i_in.ready = w_en;

    assign w_r0 = DW'(i_in.r_first);
    assign w_r1 = DW'(i_in.r_second);
    assign w_r2 = DW'(i_in.r_third);
    assign w_z0 = DW'(i_in.z_first);
    assign w_z1 = DW'(i_in.z_second);
    assign w_z2 = DW'(i_in.z_third);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a1        <= w_r1 - w_r0;
            r_a2        <= w_z2 - w_z0;
            r_c1        <= w_r2 - w_r0;
            r_c2        <= w_z1 - w_z0;
            r1_sr       <= SW'(i_in.r_first) + SW'(i_in.r_second) + SW'(i_in.r_third);
            r1_sz       <= SW'(i_in.z_first) + SW'(i_in.z_second) + SW'(i_in.z_third);
            r1_beta[0]  <= w_z1 - w_z2;
            r1_beta[1]  <= w_z2 - w_z0;
            r1_beta[2]  <= w_z0 - w_z1;
            r1_gamma[0] <= w_r2 - w_r1;
            r1_gamma[1] <= w_r0 - w_r2;
            r1_gamma[2] <= w_r1 - w_r0;
            r_pm        <= PW'(atb_pkg::mag_diff(r_a1)) * PW'(atb_pkg::mag_diff(r_a2));
            r_qm        <= PW'(atb_pkg::mag_diff(r_c1)) * PW'(atb_pkg::mag_diff(r_c2));
            r_pneg      <= r_a1[DW-1] ^ r_a2[DW-1];
            r_qneg      <= r_c1[DW-1] ^ r_c2[DW-1];
            r2_sr       <= r1_sr;
            r2_sz       <= r1_sz;
            r2_beta     <= r1_beta;
            r2_gamma    <= r1_gamma;
        end
    end

    always_comb begin
        if (r_pneg != r_qneg) begin
            w_am   = AW'(r_pm) + AW'(r_qm);
            w_aneg = r_pneg;
        end else if (r_pm >= r_qm) begin
            w_am   = AW'(r_pm - r_qm);
            w_aneg = r_pneg;
        end else begin
            w_am   = AW'(r_qm - r_pm);
            w_aneg = !r_pneg;
        end
    end

    assign o_push      = r_v2 && !i_full;
    assign o_elem.am    = w_am;
    assign o_elem.zero  = (w_am == '0);
    assign o_elem.aneg  = w_aneg && (w_am != '0);
    assign o_elem.sr    = r2_sr;
    assign o_elem.sz    = r2_sz;
    assign o_elem.beta  = r2_beta;
    assign o_elem.gamma = r2_gamma;
endmodule

// ===== hw/rtl/atb_div.sv =====
// Shared radix-2 divider giving rounded, saturated 32-bit signed quotients.
// Depends on nothing.
module atb_div #(
    parameter int NW = 65,
    parameter int DW = 67
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_neg,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [31:0]   o_quot
);
    localparam int XW = ((NW > DW) ? NW : DW) + 2;
    localparam int RW = DW + 1;
    localparam int CW = (XW > RW + 32) ? XW : RW + 32;

    logic [XW-1:0] w_num;
    logic [RW-1:0] w_d2;
    logic          w_big;
    logic [RW:0]   w_rem2;
    logic          w_ge;
    logic [RW:0]   w_diff;
    logic [31:0]   w_lim;
    logic [31:0]   w_qs;
    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_cnt;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_den;
    logic [31:0]   r_nlo;
    logic [31:0]   r_q;
    logic          r_neg;
    logic          r_sat;

    assign w_num  = (XW'(i_num) << 1) + XW'(i_den);
    assign w_d2   = {i_den, 1'b0};
    assign w_big  = CW'(w_num) >= (CW'(w_d2) << 32);
    assign w_rem2 = {r_rem, r_nlo[31]};
    assign w_ge   = w_rem2 >= (RW + 1)'(r_den);
    assign w_diff = w_rem2 - (RW + 1)'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0 || w_big) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_neg;
            r_sat <= (i_den == '0) || w_big;
            r_cnt <= '0;
            r_rem <= RW'(w_num >> 32);
            r_nlo <= w_num[31:0];
            r_den <= w_d2;
            r_q   <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            r_rem <= w_ge ? w_diff[RW-1:0] : w_rem2[RW-1:0];
            r_nlo <= {r_nlo[30:0], 1'b0};
            r_q   <= {r_q[30:0], w_ge};
        end
    end

    assign w_lim  = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign w_qs   = (r_sat || r_q > w_lim) ? w_lim : r_q;
    assign o_quot = r_neg ? (~w_qs + 32'd1) : w_qs;
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule

// ===== hw/rtl/atb_back.sv =====
// Back part: runs the quotients of one element on the shared divider and emits results.
// Centroids use a reciprocal multiplication. Depends on atb_pkg, atb_out_if and atb_div.
module atb_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  atb_pkg::t_elem i_elem,
    input  logic           i_empty,
    output logic           o_pop,
    atb_out_if.source      o_out
);
    localparam int DW = atb_pkg::DIFF_W;
    localparam int SW = atb_pkg::SUM_W;
    localparam int AW = atb_pkg::AM_W;
    localparam int NW = DW + 2 * FRAC_BITS;

    localparam int            C3_SH  = 35;
    localparam logic [SW-1:0] C3_MUL = SW'(64'd11453246123);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [2:0] JOB_RCEN  = 3'd0;
    localparam logic [2:0] JOB_ZCEN  = 3'd1;
    localparam logic [2:0] JOB_HOOP  = 3'd2;
    localparam logic [2:0] JOB_BETA  = 3'd3;
    localparam logic [2:0] JOB_GAMMA = 3'd4;

    logic [1:0]     r_state;
    logic [2:0]     r_job;
    logic [1:0]     r_node;
    atb_pkg::t_elem r_elem;
    logic [31:0]    r_rcen, r_zcen, r_hoop, r_rad;
    logic [1:0]     r_o_node, r_o_status;
    logic [31:0]    r_o_rad, r_o_ax, r_o_hoop, r_o_area, r_o_rc, r_o_zc;
    logic           r_o_last;
    logic           r_cneg;
    logic [SW-1:0]  r_cm;

    logic           w_start;
    logic           w_neg;
    logic [NW-1:0]  w_num;
    logic [AW-1:0]  w_den;
    logic           w_busy;
    logic           w_done;
    logic [31:0]    w_quot;
    logic [DW-1:0]  w_coef;
    logic [AW:0]    w_asum;
    logic [AW:0]    w_aq;
    logic [31:0]    w_alim;
    logic [31:0]    w_aqs;
    logic [31:0]    w_area;
    logic           w_err;
    logic           w_cjob;
    logic [SW-1:0]  w_csel;
    logic [2*SW-1:0]       w_cprod;
    logic [2*SW-C3_SH-1:0] w_cq;
    logic [31:0]    w_clim;
    logic [31:0]    w_cqs;
    logic [31:0]    w_cen;
    logic           w_fin;
    logic [31:0]    w_res;

    assign w_coef = (r_job == JOB_BETA) ? r_elem.beta[r_node] : r_elem.gamma[r_node];

    always_comb begin
        unique case (r_job)
            JOB_HOOP: begin
                w_neg = r_elem.sr[SW-1];
                w_num = NW'(1) << (2 * FRAC_BITS);
                w_den = AW'(atb_pkg::mag_sum(r_elem.sr));
            end
            default: begin
                w_neg = w_coef[DW-1];
                w_num = NW'(atb_pkg::mag_diff(w_coef)) << (2 * FRAC_BITS);
                w_den = r_elem.am;
            end
        endcase
    end

    // A centroid is the sum over three, rounded, which is floor((|sum| + 1) / 3).
    assign w_cjob  = (r_job == JOB_RCEN) || (r_job == JOB_ZCEN);
    assign w_csel  = (r_job == JOB_RCEN) ? r_elem.sr : r_elem.sz;
    assign w_cprod = (2 * SW)'(r_cm) * (2 * SW)'(C3_MUL);
    assign w_cq    = w_cprod[2*SW-1:C3_SH];
    assign w_clim  = r_cneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign w_cqs   = (w_cq > (2 * SW - C3_SH)'(w_clim)) ? w_clim : w_cq[31:0];
    assign w_cen   = r_cneg ? (~w_cqs + 32'd1) : w_cqs;
    assign w_fin   = w_cjob || w_done;
    assign w_res   = w_cjob ? w_cen : w_quot;

    assign w_asum = (AW + 1)'(r_elem.am) + ((AW + 1)'(1) << FRAC_BITS);
    assign w_aq   = w_asum >> (FRAC_BITS + 1);
    assign w_alim = r_elem.aneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign w_aqs  = (w_aq > (AW + 1)'(w_alim)) ? w_alim : w_aq[31:0];
    assign w_area = r_elem.aneg ? (~w_aqs + 32'd1) : w_aqs;
    assign w_err  = r_elem.zero || r_elem.aneg;

    assign w_start = (r_state == ST_START) && !w_cjob;
    assign o_pop   = (r_state == ST_IDLE) && !i_empty;

    atb_div #(
        .NW (NW),
        .DW (AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_neg   (w_neg),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_job   <= JOB_RCEN;
            r_node  <= 2'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= JOB_RCEN;
                        r_node  <= 2'd0;
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_fin) begin
                        case (r_job)
                            JOB_RCEN: begin
                                r_job   <= JOB_ZCEN;
                                r_state <= ST_START;
                            end
                            JOB_ZCEN: begin
                                r_job   <= JOB_HOOP;
                                r_state <= w_err ? ST_OUT : ST_START;
                            end
                            JOB_HOOP: begin
                                r_job   <= JOB_BETA;
                                r_state <= ST_START;
                            end
                            JOB_BETA: begin
                                r_job   <= JOB_GAMMA;
                                r_state <= ST_START;
                            end
                            default: begin
                                r_state <= ST_OUT;
                            end
                        endcase
                    end
                end
                default: begin
                    if (o_out.ready) begin
                        if (r_o_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_job   <= JOB_BETA;
                            r_node  <= r_node + 2'd1;
                            r_state <= ST_START;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_elem <= i_elem;
        end
        if (r_state == ST_START && w_cjob) begin
            r_cneg <= w_csel[SW-1];
            r_cm   <= atb_pkg::mag_sum(w_csel) + SW'(1);
        end
        if (r_state == ST_WAIT && w_fin) begin
            case (r_job)
                JOB_RCEN: r_rcen <= w_res;
                JOB_ZCEN: begin
                    r_zcen     <= w_res;
                    r_o_node   <= 2'd0;
                    r_o_status <= r_elem.zero ? atb_pkg::STATUS_ZERO : atb_pkg::STATUS_CW;
                    r_o_rad    <= '0;
                    r_o_ax     <= '0;
                    r_o_hoop   <= '0;
                    r_o_area   <= w_area;
                    r_o_rc     <= r_rcen;
                    r_o_zc     <= w_res;
                    r_o_last   <= 1'b1;
                end
                JOB_HOOP: r_hoop <= w_res;
                JOB_BETA: r_rad  <= w_res;
                default: begin
                    r_o_node   <= r_node;
                    r_o_status <= atb_pkg::STATUS_OK;
                    r_o_rad    <= r_rad;
                    r_o_ax     <= w_res;
                    r_o_hoop   <= r_hoop;
                    r_o_area   <= w_area;
                    r_o_rc     <= r_rcen;
                    r_o_zc     <= r_zcen;
                    r_o_last   <= (r_node == 2'd2);
                end
            endcase
        end
    end

    assign o_out.valid       = (r_state == ST_OUT);
    assign o_out.node_index  = r_o_node;
    assign o_out.status      = r_o_status;
    assign o_out.radial_term = r_o_rad;
    assign o_out.axial_term  = r_o_ax;
    assign o_out.hoop_term   = r_o_hoop;
    assign o_out.tri_area    = r_o_area;
    assign o_out.r_centroid  = r_o_rc;
    assign o_out.z_centroid  = r_o_zc;
    assign o_out.last        = r_o_last;

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != atb_pkg::STATUS_OK)
            |-> (o_out.last && o_out.node_index == 2'd0))
        else $error("Error result is not a single last result.");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_busy)
        else $error("Divider started while busy.");
    a_pop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_START && r_job == JOB_RCEN))
        else $error("Element popped without starting its work.");
endmodule

// ===== hw/rtl/axisymmetric_triangle_b_matrix.sv =====
// Top level: strain-displacement terms of axisymmetric constant-strain triangles.
// Depends on atb_pkg, atb_if, atb_front, atb_fifo and atb_back.
//
//   Port   Dir  Carries
//   i_in   in   three node coordinates (r, z) of one element, signed fixed point
//   o_out  out  one result per node, or one error result, with area and centroid
//
// The front part takes a new element every cycle, unless the queue is full and an
// element waits at its end, into a two-stage pipeline and queues it. The back part
// forms each centroid by reciprocal multiplication and runs the other quotients on
// one shared divider.
// Reset clears the pipeline valids, the queue and the sequencer.
// A stalled output holds the back part; the front keeps filling the queue until it is full.
module axisymmetric_triangle_b_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    atb_in_if.sink    i_in,
    atb_out_if.source o_out
);
    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    atb_pkg::t_elem w_elem_in;
    atb_pkg::t_elem w_elem_out;

    atb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (w_push),
        .o_elem  (w_elem_in),
        .i_full  (w_full)
    );

    atb_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_elem_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_elem_out),
        .o_empty (w_empty)
    );

    atb_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (w_elem_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );
endmodule
